### hw/rtl/servo_pulse_capture_and_sequencer_assert.svh
// Assertion macros for the servo pulse capture and sequencer checker.
// No dependencies; included by the checker file only.
`ifndef SERVO_PULSE_CAPTURE_AND_SEQUENCER_ASSERT_SVH
`define SERVO_PULSE_CAPTURE_AND_SEQUENCER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SPCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SPCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/spcs_pkg.sv
// Shared constants and types for the servo pulse capture and sequencer.
// No dependencies.
`default_nettype none
package spcs_pkg;
    localparam int CHANNELS     = 4;
    localparam int CNT_W        = 16;
    localparam int LVL_W        = CHANNELS;
    localparam int SLOT_W       = $clog2(CHANNELS + 1);
    localparam int LANE_W       = $clog2(CHANNELS);
    localparam int SUM_W        = CNT_W + $clog2(CHANNELS);

    localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]  RESET_PERIOD = CNT_W'(20000);
    localparam logic [CNT_W-1:0]  RESET_GAP    = CNT_W'(500);
    localparam logic [SLOT_W-1:0] GAP_SLOT     = SLOT_W'(CHANNELS);
    localparam logic [SLOT_W-1:0] LAST_PULSE   = SLOT_W'(CHANNELS - 1);

    typedef logic [CHANNELS-1:0][CNT_W-1:0] t_widths;

    typedef struct packed {
        logic [LVL_W-1:0]  levels;
        logic [SLOT_W-1:0] slot;
        t_widths           widths;
    } t_result;
endpackage
`default_nettype wire

### hw/rtl/servo_pulse_capture_and_sequencer.sv
// Top level of the servo pulse capture and sequencer.
// Depends on spcs_pkg, spcs_capture_lane and spcs_sequencer.
// One input transaction is one microsecond tick and is taken every clock
// cycle unless o_in_stall is high: four capture lanes run side by side and
// the sequencer counts slots in the same cycle. Each result is registered
// in the output register, or in the skid register while that one is stalled;
// both entries let ticks keep arriving while a result waits, so o_in_stall
// rises only once both entries hold untaken results. After reset the
// sequencer sits in a 500-tick gap. The frame period register may be written
// at any time while no transaction is in flight; o_cfg_ready is always high.
`default_nettype none
module servo_pulse_capture_and_sequencer
    import spcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [LVL_W-1:0]  i_in_levels,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [LVL_W-1:0]  o_out_levels,
    output logic      [SLOT_W-1:0] o_current_slot,
    output logic      [CNT_W-1:0]  o_width_ch1,
    output logic      [CNT_W-1:0]  o_width_ch2,
    output logic      [CNT_W-1:0]  o_width_ch3,
    output logic      [CNT_W-1:0]  o_width_ch4,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CNT_W-1:0]  i_cfg_data
);
    logic [CNT_W-1:0]  r_period;
    logic              r_out_v;
    logic              r_skid_v;
    t_result           r_out;
    t_result           r_skid;
    t_result           res;
    t_widths           widths;
    logic [SLOT_W-1:0] slot;
    logic              tick;
    logic              take;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_v;
    assign tick        = i_in_valid & ~r_skid_v;
    assign take        = r_out_v & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= RESET_PERIOD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_period <= i_cfg_data;
        end
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        spcs_capture_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tick  (tick),
            .i_level (i_in_levels[g]),
            .o_width (widths[g])
        );
    end

    spcs_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_widths (widths),
        .i_period (r_period),
        .o_slot   (slot)
    );

    always_comb begin
        res.levels = (slot == GAP_SLOT) ? '0 : LVL_W'(1) << slot;
        res.slot   = slot;
        res.widths = widths;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (tick) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v  <= r_skid_v;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            if (!r_out_v || take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (take && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_out_levels   = r_out.levels;
    assign o_current_slot = r_out.slot;
    assign o_width_ch1    = r_out.widths[0];
    assign o_width_ch2    = r_out.widths[1];
    assign o_width_ch3    = r_out.widths[2];
    assign o_width_ch4    = r_out.widths[3];
endmodule
`default_nettype wire

### hw/rtl/spcs_capture_lane.sv
// One pulse capture lane: edge detect, saturating tick counter, width register.
// Depends on spcs_pkg.
`default_nettype none
module spcs_capture_lane
    import spcs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_tick,
    input  wire logic             i_level,
    output logic      [CNT_W-1:0] o_width
);
    logic             r_prev;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_width;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] n_width;
    logic             rise;
    logic             fall;

    assign rise = i_level & ~r_prev;
    assign fall = ~i_level & r_prev;

    always_comb begin
        if (rise) begin
            n_cnt = '0;
        end else if (r_cnt == CNT_MAX) begin
            n_cnt = r_cnt;
        end else begin
            n_cnt = r_cnt + CNT_W'(1);
        end
        n_width = fall ? n_cnt : r_width;
    end

    // width as it stands after this tick's capture
    assign o_width = n_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_cnt   <= '0;
            r_width <= '0;
        end else if (i_tick) begin
            r_prev  <= i_level;
            r_cnt   <= n_cnt;
            r_width <= n_width;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/spcs_sequencer.sv
// Output slot sequencer: merges lane widths into frame slot lengths and gap.
// Depends on spcs_pkg.
`default_nettype none
module spcs_sequencer
    import spcs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tick,
    input  wire t_widths           i_widths,
    input  wire logic  [CNT_W-1:0] i_period,
    output logic       [SLOT_W-1:0] o_slot
);
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_rem;
    t_widths           r_len;
    logic [CNT_W-1:0]  r_per;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_gap;

    logic [SLOT_W-1:0] n_slot;
    logic [CNT_W-1:0]  n_rem;
    logic [CNT_W-1:0]  next_len;
    logic [SLOT_W-1:0] inc_slot;
    logic              frame_start;
    logic [SUM_W-1:0]  n_sum_w;

    assign inc_slot    = r_slot + SLOT_W'(1);
    assign frame_start = (r_rem <= CNT_W'(1)) && (r_slot == GAP_SLOT);

    always_comb begin
        if (r_slot == GAP_SLOT) begin
            next_len = i_widths[0];
        end else if (r_slot == LAST_PULSE) begin
            next_len = r_gap;
        end else begin
            next_len = r_len[inc_slot[LANE_W-1:0]];
        end
        if (r_rem <= CNT_W'(1)) begin
            n_slot = (r_slot == GAP_SLOT) ? '0 : inc_slot;
            n_rem  = (next_len == '0) ? CNT_W'(1) : next_len;
        end else begin
            n_slot = r_slot;
            n_rem  = r_rem - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= GAP_SLOT;
            r_rem  <= RESET_GAP;
        end else if (i_tick) begin
            r_slot <= n_slot;
            r_rem  <= n_rem;
        end
    end

    // frame latch; sum, then gap, are registered from it well before slot 4 is due
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_per <= RESET_PERIOD;
        end else if (i_tick && frame_start) begin
            r_len <= i_widths;
            r_per <= i_period;
        end
    end

    always_comb begin
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            acc = acc + SUM_W'(r_len[k]);
        end
        n_sum_w = acc;
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum_w;
        r_gap <= (r_sum < SUM_W'(r_per)) ? CNT_W'(SUM_W'(r_per) - r_sum) : '0;
    end

    assign o_slot = r_slot;
endmodule
`default_nettype wire

### hw/rtl/spcs_checker.sv
// Port-level checker for the servo pulse capture and sequencer, with its bind.
// Depends on spcs_pkg and servo_pulse_capture_and_sequencer_assert.svh.
`default_nettype none
`include "servo_pulse_capture_and_sequencer_assert.svh"
module spcs_checker
    import spcs_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_stall,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [LVL_W-1:0]  o_out_levels,
    input wire logic [SLOT_W-1:0] o_current_slot,
    input wire logic [CNT_W-1:0]  o_width_ch1
);
    `SPCS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_levels) && $stable(o_current_slot) && $stable(o_width_ch1), "stalled transaction changed")
    `SPCS_ASSERT_NOW(a_slot_range, o_out_valid, o_current_slot <= GAP_SLOT, "slot out of range")
    `SPCS_ASSERT_NOW(a_gap_quiet, o_out_valid && o_current_slot == GAP_SLOT, o_out_levels == '0, "output high during gap")
    `SPCS_ASSERT_NOW(a_pulse_onehot, o_out_valid && o_current_slot < GAP_SLOT, $onehot(o_out_levels) && o_out_levels == (LVL_W'(1) << o_current_slot), "pulse level mismatch")
    `SPCS_ASSERT_NOW(a_stall_full, o_in_stall, o_out_valid, "input stalled with output empty")
endmodule

bind servo_pulse_capture_and_sequencer spcs_checker u_spcs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_levels   (o_out_levels),
    .o_current_slot (o_current_slot),
    .o_width_ch1    (o_width_ch1)
);
`default_nettype wire

### bench/servo_pulse_capture_and_sequencer_checker.sv
// Checker for the servo pulse capture and sequencer: follows the tick, config and
// result transactions, predicts each result and compares it field by field.
// Depends on spcs_pkg; instantiated beside the block by the testbench top.
module servo_pulse_capture_and_sequencer_checker
    import spcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [LVL_W-1:0]  i_in_levels,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [LVL_W-1:0]  i_out_levels,
    input  logic [SLOT_W-1:0] i_current_slot,
    input  logic [CNT_W-1:0]  i_width_ch1,
    input  logic [CNT_W-1:0]  i_width_ch2,
    input  logic [CNT_W-1:0]  i_width_ch3,
    input  logic [CNT_W-1:0]  i_width_ch4,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CNT_W-1:0]  period;
    logic [LVL_W-1:0]  lane_prev;
    logic [CNT_W-1:0]  run_count [CHANNELS];
    logic [CNT_W-1:0]  held_width [CHANNELS];
    logic [CNT_W-1:0]  slot_len [CHANNELS+1];
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  slot_left;
    t_result           expected_ticks [$];

    initial begin
        o_errors      = 0;
        o_outstanding = 0;
    end

    task automatic log_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        o_errors++;
    endtask

    always @(posedge i_clk) begin : watch
        logic [SUM_W-1:0]  width_sum;
        logic [SLOT_W-1:0] next_slot;
        t_result           want;
        t_result           got;
        t_widths           seen;
        if (!i_rst_n) begin
            period    = RESET_PERIOD;
            lane_prev = '0;
            for (int k = 0; k < CHANNELS; k++) begin
                run_count[k]  = '0;
                held_width[k] = '0;
            end
            for (int k = 0; k <= CHANNELS; k++) begin
                slot_len[k] = '0;
            end
            slot      = GAP_SLOT;
            slot_left = RESET_GAP;
            expected_ticks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                period = i_cfg_data;
            end

            // result side first, so a tick taken at this edge cannot satisfy it
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    log_mismatch("result transaction with no tick outstanding");
                end else begin
                    want = expected_ticks.pop_front();
                    seen = {i_width_ch4, i_width_ch3, i_width_ch2, i_width_ch1};
                    if (i_out_levels !== want.levels) begin
                        log_mismatch($sformatf("out_levels %h, expected %h",
                                               i_out_levels, want.levels));
                    end
                    if (i_current_slot !== want.slot) begin
                        log_mismatch($sformatf("current_slot %0d, expected %0d",
                                               i_current_slot, want.slot));
                    end
                    for (int k = 0; k < CHANNELS; k++) begin
                        if (seen[k] !== want.widths[k]) begin
                            log_mismatch($sformatf("width_ch%0d %0d, expected %0d",
                                                   k + 1, seen[k], want.widths[k]));
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                // capture: rising edge restarts, otherwise count up and saturate
                for (int k = 0; k < CHANNELS; k++) begin
                    if (i_in_levels[k] && !lane_prev[k]) begin
                        run_count[k] = '0;
                    end else if (run_count[k] != CNT_MAX) begin
                        run_count[k] = run_count[k] + 1'b1;
                    end
                    if (!i_in_levels[k] && lane_prev[k]) begin
                        held_width[k] = run_count[k];
                    end
                end
                lane_prev = i_in_levels;

                got.levels = (slot < GAP_SLOT) ? (LVL_W'(1) << slot) : '0;
                got.slot   = slot;
                for (int k = 0; k < CHANNELS; k++) begin
                    got.widths[k] = held_width[k];
                end
                expected_ticks.push_back(got);

                // sequencer: a new frame latches the widths and works out the gap
                if (slot_left <= 1) begin
                    if (slot == GAP_SLOT) begin
                        next_slot = '0;
                        width_sum = '0;
                        for (int k = 0; k < CHANNELS; k++) begin
                            slot_len[k] = held_width[k];
                            width_sum   = width_sum + SUM_W'(held_width[k]);
                        end
                        slot_len[CHANNELS] = (width_sum < SUM_W'(period)) ?
                            CNT_W'(SUM_W'(period) - width_sum) : '0;
                    end else begin
                        next_slot = slot + 1'b1;
                    end
                    slot      = next_slot;
                    slot_left = (slot_len[next_slot] == '0) ? CNT_W'(1) : slot_len[next_slot];
                end else begin
                    slot_left = slot_left - 1'b1;
                end
            end
        end
        o_outstanding = expected_ticks.size();
    end
endmodule

### bench/servo_pulse_capture_and_sequencer_tb.sv
// Testbench top for the servo pulse capture and sequencer: clock, reset, tick and
// config stimulus, result-side stalls and the verdict.
// Depends on spcs_pkg, the block and servo_pulse_capture_and_sequencer_checker.
module servo_pulse_capture_and_sequencer_tb;
    import spcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [LVL_W-1:0]  i_in_levels;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [LVL_W-1:0]  o_out_levels;
    logic [SLOT_W-1:0] o_current_slot;
    logic [CNT_W-1:0]  o_width_ch1;
    logic [CNT_W-1:0]  o_width_ch2;
    logic [CNT_W-1:0]  o_width_ch3;
    logic [CNT_W-1:0]  o_width_ch4;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data;
    int                errors;
    int                outstanding;

    servo_pulse_capture_and_sequencer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_levels    (i_in_levels),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_levels   (o_out_levels),
        .o_current_slot (o_current_slot),
        .o_width_ch1    (o_width_ch1),
        .o_width_ch2    (o_width_ch2),
        .o_width_ch3    (o_width_ch3),
        .o_width_ch4    (o_width_ch4),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    servo_pulse_capture_and_sequencer_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_levels    (i_in_levels),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_levels   (o_out_levels),
        .i_current_slot (o_current_slot),
        .i_width_ch1    (o_width_ch1),
        .i_width_ch2    (o_width_ch2),
        .i_width_ch3    (o_width_ch3),
        .i_width_ch4    (o_width_ch4),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_errors       (errors),
        .o_outstanding  (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // channel four stays low here so the first frame latches a zero width
    logic [LVL_W-1:0] opening [21] = '{4'h0, 4'h7, 4'h0, 4'h7, 4'h7, 4'h0, 4'h1,
                                       4'h3, 4'h7, 4'h6, 4'h4, 4'h0, 4'h5, 4'h2,
                                       4'h5, 4'h2, 4'h1, 4'h1, 4'h1, 4'h0, 4'h3};
    // drop the long-held channel one, then a two-tick pulse before the next frame
    logic [LVL_W-1:0] recapture [4] = '{4'h0, 4'h1, 4'h1, 4'h0};

    int               burst_left = 0;
    int               stall_left = 0;
    int               stall_pct  = 0;
    int               run_left [CHANNELS] = '{default: 0};
    logic [LVL_W-1:0] pulse_lv = '0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            case ($urandom_range(3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            stall_left = $urandom_range(1, 120);
        end
        stall_left--;
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_tick(input logic [LVL_W-1:0] lv);
        int idle_cycles;
        if (burst_left == 0) begin
            burst_left  = $urandom_range(1, 40);
            idle_cycles = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (idle_cycles > 0) begin
                i_in_valid <= 1'b0;
                repeat (idle_cycles) @(posedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_in_levels <= lv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [CNT_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // servo-like pulse trains per channel with the odd noisy tick;
    // keep masks channels off, hold_high forces channels high
    task automatic run_pulses(input int ticks, input int max_run,
                              input logic [LVL_W-1:0] keep,
                              input logic [LVL_W-1:0] hold_high);
        logic [LVL_W-1:0] lv;
        repeat (ticks) begin
            for (int k = 0; k < CHANNELS; k++) begin
                if (run_left[k] == 0) begin
                    pulse_lv[k] = !pulse_lv[k];
                    run_left[k] = ($urandom_range(3) == 0) ? $urandom_range(1, 3)
                                                           : $urandom_range(1, max_run);
                end
                run_left[k]--;
            end
            lv = ($urandom_range(15) == 0) ? LVL_W'($urandom_range(15)) : pulse_lv;
            send_tick((lv & keep) | hold_high);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_levels = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening[i]) send_tick(opening[i]);
        run_pulses(350, 40, 4'b0111, 4'b0000);

        // period 0: every gap held one tick; channel one long high, four long low
        write_period('0);
        run_pulses(250, 60, 4'b0110, 4'b0001);
        foreach (recapture[i]) send_tick(recapture[i]);

        write_period(CNT_W'($urandom_range(200, 3000)));
        run_pulses(300, 200, '1, '0);

        // short period, width sums often reach it
        write_period(CNT_W'($urandom_range(1, 60)));
        run_pulses(225, 30, '1, '0);

        write_period(CNT_MAX);
        run_pulses(100, 40, '1, '0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && outstanding == 0) begin
            $display("servo_pulse_capture_and_sequencer_tb: done, clean");
        end else begin
            $display("servo_pulse_capture_and_sequencer_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("servo_pulse_capture_and_sequencer_tb: done, errors");
        $finish;
    end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/spcs_pkg.sv
hw/rtl/spcs_capture_lane.sv
hw/rtl/spcs_sequencer.sv
hw/rtl/servo_pulse_capture_and_sequencer.sv
hw/rtl/spcs_checker.sv
bench/servo_pulse_capture_and_sequencer_checker.sv
bench/servo_pulse_capture_and_sequencer_tb.sv
